// File: design/mcp_pkg.sv
// Shared constants, request codes and the control word type for the multichannel PWM block.
package mcp_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned PERIOD   = 32;

  localparam int unsigned CH_W   = 3;
  localparam int unsigned WIDTH_W = 8;
  localparam int unsigned PINS_W = 8;
  localparam int unsigned PCNT_W = 6;

  localparam logic [PCNT_W-1:0]  PERIOD_RELOAD = PCNT_W'(PERIOD);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET   = WIDTH_W'(PERIOD / 2);

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WIDTH = 1'b1;

  // Control word broadcast from the top level to every channel cell.
  typedef struct packed {
    logic               tick;
    logic               period_start;
    logic               wr;
    logic [CH_W-1:0]    wr_ch;
    logic [WIDTH_W-1:0] wr_width;
  } mcp_ctrl_t;

endpackage

// File: design/mcp_period.sv
// Shared period down-counter that flags the start of each PWM period.
module mcp_period (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tick_i,
  output logic period_start_o
);
  import mcp_pkg::*;

  logic [PCNT_W-1:0] count_q, count_d;

  // A tick at a count of one is the period start, and the count reloads instead of reaching zero.
  // A count of zero cannot arise from reset; it wraps to the top and keeps going.
  assign period_start_o = tick_i && (count_q == PCNT_W'(1));

  always_comb begin
    count_d = count_q;
    if (tick_i) begin
      if (period_start_o) begin
        count_d = PERIOD_RELOAD;
      end else begin
        count_d = count_q - PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= PERIOD_RELOAD;
    end else begin
      count_q <= count_d;
    end
  end

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0)
    else $error("period counter reached zero");

endmodule

// File: design/mcp_cell.sv
// One PWM channel cell: width register, pulse counter and pin level, chained into the pin word.
module mcp_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mcp_pkg::CH_W-1:0]  cell_idx_i,
  input  mcp_pkg::mcp_ctrl_t        ctrl_i,
  input  logic [mcp_pkg::PINS_W-1:0] pins_i,
  output logic [mcp_pkg::PINS_W-1:0] pins_o
);
  import mcp_pkg::*;

  logic [WIDTH_W-1:0] width_q, width_d;
  logic [WIDTH_W-1:0] pulse_q, pulse_d;
  logic               level_q, level_d;

  always_comb begin
    width_d = width_q;
    pulse_d = pulse_q;
    level_d = level_q;
    if (ctrl_i.wr && (ctrl_i.wr_ch == cell_idx_i)) begin
      width_d = ctrl_i.wr_width;
    end
    if (ctrl_i.tick) begin
      if (ctrl_i.period_start) begin
        level_d = 1'b1;
        pulse_d = width_q;
      end else if (pulse_q != '0) begin
        pulse_d = pulse_q - WIDTH_W'(1);
        if (pulse_q == WIDTH_W'(1)) begin
          level_d = 1'b0;
        end
      end
    end
  end

  // The updated level joins the word handed on to the next cell.
  assign pins_o = pins_i | (PINS_W'(level_d) << cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      pulse_q <= '0;
      level_q <= 1'b0;
    end else begin
      width_q <= width_d;
      pulse_q <= pulse_d;
      level_q <= level_d;
    end
  end

  a_pulse_implies_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulse_q != '0) |-> level_q)
    else $error("pulse counter running while pin is low");

endmodule

// File: design/multichannel_counter_pwm_top.sv
// Top level of the multichannel PWM generator: period counter, cell chain and output stage.
//
//   Channel  Direction  Handshake                 Word
//   in       input      in_valid_i / in_stall_o   req_type_i, channel_i, width_i
//   out      output     out_valid_o / out_stall_i pins_o
//
// Every accepted word produces exactly one output word, the pin levels after
// that word has been applied; a width write returns the levels unchanged.
// The block takes one word per cycle while the skid register has room: the
// period counter and all channel cells update in the same cycle, and the
// output word is registered. A two-entry output stage (output register plus
// skid register) absorbs a stall, so the input side is stalled only once the
// skid register is full. Reset clears the pins and pulse counters, reloads
// the period counter and sets every width to half the period.
module multichannel_counter_pwm_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [mcp_pkg::CH_W-1:0]    channel_i,
  input  logic [mcp_pkg::WIDTH_W-1:0] width_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mcp_pkg::PINS_W-1:0]  pins_o
);
  import mcp_pkg::*;

  logic               accept;
  logic               period_start;
  mcp_ctrl_t          ctrl;
  logic [PINS_W-1:0]  chain [CHANNELS+1];
  logic [PINS_W-1:0]  result;

  logic               out_valid_q, out_valid_d;
  logic [PINS_W-1:0]  out_pins_q, out_pins_d;
  logic               skid_valid_q, skid_valid_d;
  logic [PINS_W-1:0]  skid_pins_q, skid_pins_d;

  // A word is taken whenever the skid register has room.
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  mcp_period u_period (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (ctrl.tick),
    .period_start_o(period_start)
  );

  // The control word goes to every cell alike; a write only reaches channels
  // that exist, so a write beyond the channel count is dropped.
  always_comb begin
    ctrl.tick         = accept && (req_type_i == REQ_TICK);
    ctrl.period_start = period_start;
    ctrl.wr           = accept && (req_type_i == REQ_WIDTH);
    ctrl.wr_ch        = channel_i;
    ctrl.wr_width     = width_i;
  end

  // Each cell ORs its own pin into the word handed along the chain, so the
  // last cell delivers the complete pin word. Bits above the channel count
  // are never set.
  assign chain[0] = '0;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    mcp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_idx_i(CH_W'(g)),
      .ctrl_i    (ctrl),
      .pins_i    (chain[g]),
      .pins_o    (chain[g+1])
    );
  end

  assign result = chain[CHANNELS];

  // Output stage. When the output register is free or being drained, it is
  // refilled from the skid register first and otherwise from the new word.
  // When it is held by a stall, a new word waits in the skid register.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_pins_d   = out_pins_q;
    skid_valid_d = skid_valid_q;
    skid_pins_d  = skid_pins_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_pins_d   = skid_pins_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_pins_d  = result;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_pins_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pins_q  <= out_pins_d;
    skid_pins_q <= skid_pins_d;
  end

  assign out_valid_o = out_valid_q;
  assign pins_o      = out_pins_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_word_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (!out_valid_q || !out_stall_i)) |=> (out_valid_q && !skid_valid_q))
    else $error("accepted word did not reach the output register");

  a_tick_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.tick && ctrl.wr))
    else $error("tick and width write in the same cycle");

endmodule

// File: test/mcp_pin_checker.sv
// Checker that predicts the PWM pin levels and compares them with the output words of the block.
`timescale 1ns / 100ps

module mcp_pin_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        req_type_i,
  input  logic [mcp_pkg::CH_W-1:0]    channel_i,
  input  logic [mcp_pkg::WIDTH_W-1:0] width_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [mcp_pkg::PINS_W-1:0]  pins_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          period_starts_o
);
  import mcp_pkg::*;

  localparam int unsigned REPORT_CAP = 20;
  localparam logic [PINS_W-1:0] CH_MASK = PINS_W'((1 << CHANNELS) - 1);

  logic [PCNT_W-1:0]  period_cnt;
  logic [WIDTH_W-1:0] width_mem [CHANNELS];
  logic [WIDTH_W-1:0] pulse_cnt [CHANNELS];
  logic [PINS_W-1:0]  pin_lvl;
  logic [PINS_W-1:0]  oldest_pins;
  logic [PINS_W-1:0]  pin_words_q [$];

  task automatic report_mismatch(input string what, input logic [PINS_W-1:0] want,
                                 input logic [PINS_W-1:0] got);
    if (fail_count_o < REPORT_CAP) begin
      $display("%0t pin checker: %s, expected %h, got %h", $time, what, want, got);
    end
    fail_count_o++;
  endtask

  // Applies one word to the predicted generator state.
  task automatic step_pwm(input logic req, input logic [CH_W-1:0] ch,
                          input logic [WIDTH_W-1:0] w);
    if (req == REQ_TICK) begin
      // The period counter is six bits wide and wraps if it is ever found at zero.
      period_cnt = period_cnt - 1'b1;
      if (period_cnt == '0) begin
        pin_lvl = pin_lvl | CH_MASK;
        for (int n = 0; n < CHANNELS; n++) begin
          pulse_cnt[n] = width_mem[n];
        end
        period_cnt = PERIOD_RELOAD;
        period_starts_o++;
      end else begin
        for (int n = 0; n < CHANNELS; n++) begin
          if (pulse_cnt[n] != '0) begin
            pulse_cnt[n] = pulse_cnt[n] - 1'b1;
            if (pulse_cnt[n] == '0) pin_lvl[n] = 1'b0;
          end
        end
      end
    end else if (ch < CHANNELS) begin
      width_mem[ch] = w;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_cnt = PERIOD_RELOAD;
      pin_lvl = '0;
      for (int n = 0; n < CHANNELS; n++) begin
        width_mem[n] = WIDTH_RESET;
        pulse_cnt[n] = '0;
      end
      pin_words_q.delete();
      pending_o = 0;
    end else begin
      // A word leaving the block now was caused by an earlier input word.
      if (out_valid_i && !out_stall_i) begin
        if (pin_words_q.size() == 0) begin
          report_mismatch("output word with nothing pending", '0, pins_i);
        end else begin
          oldest_pins = pin_words_q.pop_front();
          checked_o++;
          if (pins_i !== oldest_pins) report_mismatch("pin levels differ", oldest_pins, pins_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_pwm(req_type_i, channel_i, width_i);
        pin_words_q.push_back(pin_lvl & CH_MASK);
      end
      pending_o = pin_words_q.size();
    end
  end

endmodule

// File: test/tb_multichannel_counter_pwm_top.sv
// Testbench top: stimulus, idling on both channels, watchdog and verdict for the PWM block.
`timescale 1ns / 100ps

module tb_multichannel_counter_pwm_top;
  import mcp_pkg::*;

  // A correct run never goes anywhere near this many cycles without a word
  // moving on one of the two channels, even with both sides idling at random.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS = 1600;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               req_type_i  = REQ_TICK;
  logic [CH_W-1:0]    channel_i   = '0;
  logic [WIDTH_W-1:0] width_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PINS_W-1:0]  pins_o;

  // While this is set neither side idles, so the block runs at full rate.
  logic steady = 1'b0;

  int fail_count;
  int pending_words;
  int checked_words;
  int period_starts;
  int ticks_sent;
  int writes_sent;

  multichannel_counter_pwm_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .channel_i   (channel_i),
    .width_i     (width_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pins_o      (pins_o)
  );

  // The checker watches both channels, predicts every output word and counts
  // mismatches; this module only makes stimulus and gives the verdict.
  mcp_pin_checker pin_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .channel_i       (channel_i),
    .width_i         (width_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pins_i          (pins_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words),
    .checked_o       (checked_words),
    .period_starts_o (period_starts)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiving side stalls with a chance of 38 in a hundred, except in the
  // steady stretch. The stall is drawn afresh at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 38);
    end
  end

  // Offers one word and returns at the edge at which it is accepted. Valid is
  // only lowered for an idle gap, so back-to-back words keep it high, and the
  // payload is never touched while the word waits out a stall.
  task automatic send_word(input logic req, input logic [CH_W-1:0] ch,
                           input logic [WIDTH_W-1:0] w);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    channel_i  <= ch;
    width_i    <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req == REQ_TICK) ticks_sent++;
    else writes_sent++;
  endtask

  // Widths mostly fall around the period, where the interesting edges are:
  // zero, one, just below the period and the period itself. The rest cover the
  // whole field, so every width bit is exercised.
  function automatic logic [WIDTH_W-1:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return WIDTH_W'($urandom_range(PERIOD + 1));
    if (sel < 70) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return WIDTH_W'(1);
        2:       return WIDTH_W'(PERIOD - 1);
        default: return WIDTH_W'(PERIOD);
      endcase
    end
    return WIDTH_W'($urandom);
  endfunction

  initial begin : stimulus
    int sent;
    int run_len;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first ticks come before any period start, so the
    // pins must stay low; their channel and width fields are ignored, and are
    // set to both extremes to show it.
    send_word(REQ_TICK, '1, '1);
    send_word(REQ_TICK, '0, '0);
    send_word(REQ_TICK, CH_W'(5), WIDTH_W'(8'h5A));

    // One width per channel: zero and the period or more keep a channel high
    // for the whole period, one gives the shortest pulse, and the others lie
    // between. Widths of all zeros and all ones toggle every width bit.
    send_word(REQ_WIDTH, CH_W'(0), '0);
    send_word(REQ_WIDTH, CH_W'(1), WIDTH_W'(1));
    send_word(REQ_WIDTH, CH_W'(2), WIDTH_W'(PERIOD - 1));
    send_word(REQ_WIDTH, CH_W'(3), WIDTH_W'(PERIOD));
    send_word(REQ_WIDTH, CH_W'(4), '1);
    send_word(REQ_WIDTH, CH_W'(5), WIDTH_W'(2));
    send_word(REQ_WIDTH, CH_W'(6), WIDTH_W'(PERIOD / 2 + 1));
    send_word(REQ_WIDTH, CH_W'(7), WIDTH_W'(8'h80));

    // Random part. It is built from runs: a short burst of width writes with
    // random channels, or a run of ticks that can be long enough to cross a period start.
    // Tick words carry random channel and width fields, which must be ignored.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      steady = (sent >= 700) && (sent < 1000);
      if ($urandom_range(99) < 25) begin
        run_len = $urandom_range(3, 1);
        repeat (run_len) begin
          send_word(REQ_WIDTH, CH_W'($urandom), pick_width());
          sent++;
        end
      end else begin
        run_len = $urandom_range(40, 1);
        repeat (run_len) begin
          send_word(REQ_TICK, CH_W'($urandom), WIDTH_W'($urandom));
          sent++;
        end
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain: every accepted word owes exactly one output word. The checker
    // only counts the last word at the edge that accepted it, so the pending
    // count is trusted only after the next edge. The watchdog ends the run
    // if the output words stop coming.
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("summary: %0d ticks and %0d width writes sent, %0d output words checked",
             ticks_sent, writes_sent, checked_words);
    $display("summary: %0d period starts predicted, %0d mismatches", period_starts,
             fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Counts cycles in which no word moves on either channel.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
